### hw/rtl/tor_pkg.sv
// Types, codes and lookup functions shared by the Telnet option negotiator.
package tor_pkg;

  localparam int NumEntries = 5;
  localparam int NumSides   = 8;

  typedef enum logic [1:0] {
    CMD_WILL = 2'd0,
    CMD_WONT = 2'd1,
    CMD_DO   = 2'd2,
    CMD_DONT = 2'd3
  } cmd_e;

  localparam logic [1:0] OP_RECEIVE       = 2'd0;
  localparam logic [1:0] OP_REQUEST       = 2'd1;
  localparam logic [1:0] OP_SESSION_RESET = 2'd2;

  localparam logic [2:0] REQ_MUST_NOT   = 3'd0;
  localparam logic [2:0] REQ_BETTER_NOT = 3'd1;
  localparam logic [2:0] REQ_NEUTRAL    = 3'd2;
  localparam logic [2:0] REQ_BETTER     = 3'd3;
  localparam logic [2:0] REQ_MUST       = 3'd4;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;

  localparam logic [2:0] CFG_BINARY_LOCAL  = 3'd0;
  localparam logic [2:0] CFG_BINARY_REMOTE = 3'd1;
  localparam logic [2:0] CFG_ECHO_REMOTE   = 3'd2;
  localparam logic [2:0] CFG_SGA_REMOTE    = 3'd3;
  localparam logic [2:0] CFG_TTYPE_LOCAL   = 3'd4;

  localparam logic [2:0] ENTRY_DEFAULT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WALK = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       emit;
    logic       emit_empty;
    logic       last;
    logic [2:0] side;
  } tor_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       is_request;
    logic       out_free;
    logic [7:0] need;
  } tor_status_t;

  typedef struct packed {
    logic       send_valid;
    logic [1:0] send_command;
    logic [7:0] send_option;
    logic       refused;
    logic       binary_send;
    logic       binary_receive;
    logic       sga_enabled;
    logic       requests_sent;
    logic       last;
  } tor_result_t;

  function automatic logic [2:0] entry_of(input logic [7:0] opt);
    logic [2:0] e;
    unique case (opt)
      OPT_BINARY: e = 3'd0;
      OPT_ECHO:   e = 3'd1;
      OPT_SGA:    e = 3'd2;
      OPT_TTYPE:  e = 3'd3;
      default:    e = ENTRY_DEFAULT;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] option_of(input logic [1:0] e);
    logic [7:0] opt;
    unique case (e)
      2'd0:    opt = OPT_BINARY;
      2'd1:    opt = OPT_ECHO;
      2'd2:    opt = OPT_SGA;
      default: opt = OPT_TTYPE;
    endcase
    return opt;
  endfunction

endpackage

### hw/rtl/tor_in_if.sv
// Input channel of the option negotiator: operation, command and option number.
interface tor_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] command;
  logic [7:0] option_code;

  modport source (output valid, output operation, output command, output option_code,
                  input ready);
  modport sink (input valid, input operation, input command, input option_code,
                output ready);
endinterface

### hw/rtl/tor_out_if.sv
// Result channel of the option negotiator: command to send plus status.
interface tor_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [1:0] send_command;
  logic [7:0] send_option;
  logic       refused;
  logic       binary_send;
  logic       binary_receive;
  logic       sga_enabled;
  logic       requests_sent;
  logic       last;

  modport source (output valid, output send_valid, output send_command,
                  output send_option, output refused, output binary_send,
                  output binary_receive, output sga_enabled, output requests_sent,
                  output last, input ready);
  modport sink (input valid, input send_valid, input send_command,
                input send_option, input refused, input binary_send,
                input binary_receive, input sga_enabled, input requests_sent,
                input last, output ready);
endinterface

### hw/rtl/tor_ctrl.sv
// Controller of the option negotiator: sequences item capture, execution and the request walk.
module tor_ctrl
  import tor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tor_status_t status_i,
  output tor_cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] side_q, side_d;
  logic       later_need;

  // Any option side after the current one that still needs a request.
  always_comb begin
    later_need = 1'b0;
    for (int i = 0; i < NumSides; i++) begin
      if ((3'(i) > side_q) && status_i.need[i]) begin
        later_need = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.side = side_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_request) begin
          side_d  = '0;
          state_d = ST_WALK;
        end else if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (status_i.need[side_q]) begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = !later_need;
            side_d     = side_q + 3'd1;
            if (!later_need) begin
              state_d = ST_IDLE;
            end
          end
        end else if (side_q == 3'(NumSides - 1)) begin
          // A walk that found nothing to request still answers with one result.
          if (status_i.need == '0) begin
            if (status_i.out_free) begin
              cmd_o.emit_empty = 1'b1;
              cmd_o.last       = 1'b1;
              state_d          = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          side_d = side_q + 3'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= '0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
    end
  end

endmodule

### hw/rtl/tor_dp.sv
// Datapath of the option negotiator: requirement registers, option state and result register.
module tor_dp
  import tor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  option_code_i,
  input  tor_cmd_t    cmd_i,
  output tor_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tor_result_t result_o
);

  logic [2:0] bin_loc_req_q, bin_rem_req_q, echo_rem_req_q, sga_rem_req_q, ttype_loc_req_q;
  logic [NumEntries-1:0] loc_en_q, loc_en_d, loc_pd_q, loc_pd_d;
  logic [NumEntries-1:0] rem_en_q, rem_en_d, rem_pd_q, rem_pd_d;
  logic        sent_q, sent_d;
  logic [1:0]  op_q, cmd_q;
  logic [7:0]  opt_q;
  logic        out_valid_q, out_valid_d;
  tor_result_t res_q, res_d;

  logic [2:0]  loc_req [NumEntries];
  logic [2:0]  rem_req [NumEntries];
  logic [7:0]  need;

  // Received-command evaluation.
  logic [2:0]  rx_entry, rx_req, must_neg, better_neg;
  logic        rx_remote, rx_want, rx_en, rx_pd;
  logic        rx_en_new, rx_pd_new, rx_valid, rx_refused;
  logic [1:0]  rx_pos, rx_neg, rx_cmd;

  // Request walk evaluation.
  logic [2:0]  walk_entry;
  logic        walk_remote, walk_en;
  logic [1:0]  walk_cmd;

  logic        load;

  always_comb begin
    loc_req[0] = bin_loc_req_q;
    loc_req[1] = REQ_MUST_NOT;
    loc_req[2] = REQ_BETTER;
    loc_req[3] = ttype_loc_req_q;
    loc_req[4] = REQ_MUST_NOT;
    rem_req[0] = bin_rem_req_q;
    rem_req[1] = echo_rem_req_q;
    rem_req[2] = sga_rem_req_q;
    rem_req[3] = REQ_MUST_NOT;
    rem_req[4] = REQ_MUST_NOT;
  end

  // The default entry for unknown option codes has no side and so never asks for anything.
  always_comb begin
    for (int e = 0; e < NumEntries - 1; e++) begin
      need[2*e]   = (((loc_req[e] == REQ_MUST_NOT) || (loc_req[e] == REQ_BETTER_NOT))
                     && loc_en_q[e])
                 || (((loc_req[e] == REQ_BETTER) || (loc_req[e] == REQ_MUST))
                     && !loc_en_q[e]);
      need[2*e+1] = (((rem_req[e] == REQ_MUST_NOT) || (rem_req[e] == REQ_BETTER_NOT))
                     && rem_en_q[e])
                 || (((rem_req[e] == REQ_BETTER) || (rem_req[e] == REQ_MUST))
                     && !rem_en_q[e]);
    end
  end

  always_comb begin
    rx_entry   = entry_of(opt_q);
    rx_remote  = (cmd_q == CMD_WILL) || (cmd_q == CMD_WONT);
    rx_want    = (cmd_q == CMD_WILL) || (cmd_q == CMD_DO);
    rx_req     = rx_remote ? rem_req[rx_entry] : loc_req[rx_entry];
    rx_en      = rx_remote ? rem_en_q[rx_entry] : loc_en_q[rx_entry];
    rx_pd      = rx_remote ? rem_pd_q[rx_entry] : loc_pd_q[rx_entry];
    must_neg   = rx_want ? REQ_MUST_NOT : REQ_MUST;
    better_neg = rx_want ? REQ_BETTER_NOT : REQ_BETTER;
    unique case (cmd_q)
      CMD_WILL: begin rx_pos = CMD_DO;   rx_neg = CMD_DONT; end
      CMD_WONT: begin rx_pos = CMD_DONT; rx_neg = CMD_DO;   end
      CMD_DO:   begin rx_pos = CMD_WILL; rx_neg = CMD_WONT; end
      default:  begin rx_pos = CMD_WONT; rx_neg = CMD_WILL; end
    endcase
    rx_en_new  = rx_en;
    rx_pd_new  = rx_pd;
    rx_valid   = 1'b0;
    rx_refused = 1'b0;
    rx_cmd     = '0;
    if ((rx_req == must_neg) || (rx_req == better_neg)) begin
      if (rx_pd) begin
        rx_pd_new = 1'b0;
        if (rx_req == must_neg) begin
          rx_refused = 1'b1;
        end else if (rx_en != rx_want) begin
          rx_en_new = rx_want;
          rx_valid  = 1'b1;
          rx_cmd    = rx_pos;
        end
      end else begin
        rx_valid = 1'b1;
        rx_cmd   = rx_neg;
      end
    end else begin
      if (rx_pd) begin
        rx_pd_new = 1'b0;
      end else if (rx_en != rx_want) begin
        rx_valid = 1'b1;
        rx_cmd   = rx_pos;
      end
      rx_en_new = rx_want;
    end
  end

  always_comb begin
    walk_entry  = {1'b0, cmd_i.side[2:1]};
    walk_remote = cmd_i.side[0];
    walk_en     = walk_remote ? rem_en_q[walk_entry] : loc_en_q[walk_entry];
    if (walk_remote) begin
      walk_cmd = walk_en ? CMD_DONT : CMD_DO;
    end else begin
      walk_cmd = walk_en ? CMD_WONT : CMD_WILL;
    end
  end

  // Next state of the option table and the result to load.
  always_comb begin
    loc_en_d = loc_en_q;
    loc_pd_d = loc_pd_q;
    rem_en_d = rem_en_q;
    rem_pd_d = rem_pd_q;
    sent_d   = sent_q;
    res_d    = '0;
    load     = 1'b0;

    if (cmd_i.capture && (operation_i == OP_REQUEST)) begin
      sent_d = 1'b1;
    end

    if (cmd_i.exec) begin
      load = 1'b1;
      unique case (op_q)
        OP_RECEIVE: begin
          if (rx_remote) begin
            rem_en_d[rx_entry] = rx_en_new;
            rem_pd_d[rx_entry] = rx_pd_new;
          end else begin
            loc_en_d[rx_entry] = rx_en_new;
            loc_pd_d[rx_entry] = rx_pd_new;
          end
          res_d.send_valid   = rx_valid;
          res_d.send_command = rx_cmd;
          res_d.send_option  = rx_valid ? opt_q : 8'd0;
          res_d.refused      = rx_refused;
        end
        OP_SESSION_RESET: begin
          loc_en_d = '0;
          loc_pd_d = '0;
          rem_en_d = '0;
          rem_pd_d = '0;
          sent_d   = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.emit) begin
      load = 1'b1;
      if (walk_remote) begin
        rem_pd_d[walk_entry] = 1'b1;
      end else begin
        loc_pd_d[walk_entry] = 1'b1;
      end
      res_d.send_valid   = 1'b1;
      res_d.send_command = walk_cmd;
      res_d.send_option  = option_of(cmd_i.side[2:1]);
    end

    if (cmd_i.emit_empty) begin
      load = 1'b1;
    end

    res_d.last           = cmd_i.exec || cmd_i.last;
    res_d.binary_send    = loc_en_d[0];
    res_d.binary_receive = rem_en_d[0];
    res_d.sga_enabled    = rem_en_d[2];
    res_d.requests_sent  = sent_d;
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_loc_req_q   <= REQ_BETTER;
      bin_rem_req_q   <= REQ_BETTER;
      echo_rem_req_q  <= REQ_BETTER;
      sga_rem_req_q   <= REQ_MUST;
      ttype_loc_req_q <= REQ_NEUTRAL;
      loc_en_q        <= '0;
      loc_pd_q        <= '0;
      rem_en_q        <= '0;
      rem_pd_q        <= '0;
      sent_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_BINARY_LOCAL:  bin_loc_req_q   <= cfg_wdata_i;
          CFG_BINARY_REMOTE: bin_rem_req_q   <= cfg_wdata_i;
          CFG_ECHO_REMOTE:   echo_rem_req_q  <= cfg_wdata_i;
          CFG_SGA_REMOTE:    sga_rem_req_q   <= cfg_wdata_i;
          CFG_TTYPE_LOCAL:   ttype_loc_req_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      loc_en_q    <= loc_en_d;
      loc_pd_q    <= loc_pd_d;
      rem_en_q    <= rem_en_d;
      rem_pd_q    <= rem_pd_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      cmd_q <= command_i;
      opt_q <= option_code_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  assign status_o.is_request = (op_q == OP_REQUEST);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.need       = need;
  assign out_valid_o         = out_valid_q;
  assign result_o            = res_q;

endmodule

### hw/rtl/telnet_option_negotiator_core.sv
// Top level of the Telnet option negotiator: controller, datapath and channel wiring.
//
// Items enter on in_i: a received WILL/WONT/DO/DONT, a send-requests or a session
// reset. Each transfer on in_i gives one or more transfers on out_o, the final
// one marked by last. A received command or a session reset is captured into the
// item registers, executed in the EXEC state once the result register is free,
// and its result is registered. Send-requests walks the eight option sides
// (local, then remote, for binary, echo, suppress-go-ahead and terminal type) one
// per cycle, waiting at a side that needs a request while the result register is
// held, and emits a result for each side that disagrees with its requirement; the
// walk stops after the last such side. With nothing to request it yields a single
// empty result. The walk is the rate-setting loop: one item is worked on at a time
// and in_i is ready only while the controller is idle.
// Requirements are written on the cfg port and take effect at once; write them
// only while the block is idle. Reset restores the default requirements and
// clears all option state. A stalled receiver holds the result register and the
// walk or execution waits on it; no result is dropped.
module telnet_option_negotiator_core
  import tor_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [2:0] cfg_wdata_i,
  tor_in_if.sink     in_i,
  tor_out_if.source  out_o
);

  tor_cmd_t    cmd;
  tor_status_t status;
  tor_result_t result;

  tor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tor_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (in_i.operation),
    .command_i     (in_i.command),
    .option_code_i (in_i.option_code),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .result_o      (result)
  );

  assign out_o.send_valid     = result.send_valid;
  assign out_o.send_command   = result.send_command;
  assign out_o.send_option    = result.send_option;
  assign out_o.refused        = result.refused;
  assign out_o.binary_send    = result.binary_send;
  assign out_o.binary_receive = result.binary_receive;
  assign out_o.sga_enabled    = result.sga_enabled;
  assign out_o.requests_sent  = result.requests_sent;
  assign out_o.last           = result.last;

endmodule
